### src/cbrf_pkg.sv
`timescale 1ns / 1ps
package cbrf_pkg;

   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COEF_CUBIC    = 3'd0,
      CSR_COEF_SQUARE   = 3'd1,
      CSR_COEF_LINEAR   = 3'd2,
      CSR_COEF_CONSTANT = 3'd3,
      CSR_TOLERANCE     = 3'd4,
      CSR_MAX_ITER      = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_CONVERGED  = 2'd0,
      STATUS_EXACT      = 2'd1,
      STATUS_NO_BRACKET = 2'd2,
      STATUS_CAP        = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      COEF_SQUARE   = 2'd0,
      COEF_LINEAR   = 2'd1,
      COEF_CONSTANT = 2'd2
   } coef_sel_type;

   typedef enum logic [1:0] {
      SRC_LOW  = 2'd0,
      SRC_HIGH = 2'd1,
      SRC_MID  = 2'd2
   } src_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_BRANCH,
      ST_MID,
      ST_DIV,
      ST_DIV_END,
      ST_CHECK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic         load_req;
      logic         eval_high;
      logic         mul_step;
      logic         add_step;
      coef_sel_type coef_sel;
      logic         save_sign;
      logic         mid_step;
      logic         bisect;
      logic         err_sat;
      logic         div_start;
      logic         div_step;
      logic         div_finish;
      logic         out_load;
      status_type   out_status;
   } cmd_type;

   typedef struct packed {
      logic bracket_none;
      logic root_hit;
      logic iter_one;
      logic cur_zero;
      logic conv_ok;
      logic cap_hit;
      logic rsp_free;
   } stat_type;

endpackage

### src/cbrf_ctrl.sv
`timescale 1ns / 1ps
module cbrf_ctrl
   import cbrf_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam int DIV_LEN = VALUE_WIDTH + 7 + FRAC_BITS;
   localparam int DCW     = $clog2(DIV_LEN + 1);

   state_type    state_ff, state_in;
   coef_sel_type hcnt_ff, hcnt_in;
   src_type      src_ff, src_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic         conv_ff, conv_in;
   status_type   status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         hcnt_ff   <= COEF_SQUARE;
         src_ff    <= SRC_LOW;
         dcnt_ff   <= '0;
         conv_ff   <= 1'b0;
         status_ff <= STATUS_CONVERGED;
      end else begin
         state_ff  <= state_in;
         hcnt_ff   <= hcnt_in;
         src_ff    <= src_in;
         dcnt_ff   <= dcnt_in;
         conv_ff   <= conv_in;
         status_ff <= status_in;
      end
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      hcnt_in   = hcnt_ff;
      src_in    = src_ff;
      dcnt_in   = dcnt_ff;
      conv_in   = conv_ff;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MUL;
               src_in   = SRC_LOW;
               hcnt_in  = COEF_SQUARE;
            end
         end
         ST_MUL: state_in = ST_ADD;
         ST_ADD: begin
            unique case (hcnt_ff)
               COEF_SQUARE: begin
                  hcnt_in  = COEF_LINEAR;
                  state_in = ST_MUL;
               end
               COEF_LINEAR: begin
                  hcnt_in  = COEF_CONSTANT;
                  state_in = ST_MUL;
               end
               default: begin
                  hcnt_in  = COEF_SQUARE;
                  state_in = ST_BRANCH;
               end
            endcase
         end
         ST_BRANCH: begin
            unique case (src_ff)
               SRC_LOW: begin
                  src_in   = SRC_HIGH;
                  state_in = ST_MUL;
               end
               SRC_HIGH: begin
                  if (stat.bracket_none) begin
                     status_in = STATUS_NO_BRACKET;
                     state_in  = ST_OUT;
                  end else begin
                     state_in = ST_MID;
                  end
               end
               default: begin
                  if (stat.root_hit) begin
                     status_in = STATUS_EXACT;
                     state_in  = ST_OUT;
                  end else if (stat.iter_one) begin
                     conv_in  = 1'b1;
                     state_in = ST_CHECK;
                  end else if (stat.cur_zero) begin
                     conv_in  = 1'b0;
                     state_in = ST_CHECK;
                  end else begin
                     dcnt_in  = '0;
                     state_in = ST_DIV;
                  end
               end
            endcase
         end
         ST_MID: begin
            src_in   = SRC_MID;
            state_in = ST_MUL;
         end
         ST_DIV: begin
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCW'(DIV_LEN - 1)) state_in = ST_DIV_END;
         end
         ST_DIV_END: begin
            conv_in  = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (conv_ff && stat.conv_ok) begin
               status_in = STATUS_CONVERGED;
               state_in  = ST_OUT;
            end else if (stat.cap_hit) begin
               status_in = STATUS_CAP;
               state_in  = ST_OUT;
            end else begin
               state_in = ST_MID;
            end
         end
         ST_OUT: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.coef_sel   = hcnt_ff;
      cmd.out_status = status_ff;
      req_tready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = !reset;
            cmd.load_req = req_tvalid && !reset;
         end
         ST_MUL: cmd.mul_step = 1'b1;
         ST_ADD: cmd.add_step = 1'b1;
         ST_BRANCH: begin
            unique case (src_ff)
               SRC_LOW: begin
                  cmd.save_sign = 1'b1;
                  cmd.eval_high = 1'b1;
               end
               SRC_HIGH: ;
               default: begin
                  if (!stat.root_hit) begin
                     cmd.bisect = 1'b1;
                     if (!stat.iter_one) begin
                        cmd.err_sat   = stat.cur_zero;
                        cmd.div_start = !stat.cur_zero;
                     end
                  end
               end
            endcase
         end
         ST_MID:     cmd.mid_step   = 1'b1;
         ST_DIV:     cmd.div_step   = 1'b1;
         ST_DIV_END: cmd.div_finish = 1'b1;
         ST_CHECK: ;
         ST_OUT:     cmd.out_load   = stat.rsp_free;
         default: ;
      endcase
   end

endmodule

### src/cbrf_datapath.sv
`timescale 1ns / 1ps
module cbrf_datapath
   import cbrf_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int ITER_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output stat_type                      stat,
   input  logic signed [VALUE_WIDTH-1:0] in_low,
   input  logic signed [VALUE_WIDTH-1:0] in_high,
   input  logic signed [VALUE_WIDTH-1:0] coef_cubic,
   input  logic signed [VALUE_WIDTH-1:0] coef_square,
   input  logic signed [VALUE_WIDTH-1:0] coef_linear,
   input  logic signed [VALUE_WIDTH-1:0] coef_constant,
   input  logic [VALUE_WIDTH-1:0]        tolerance,
   input  logic [ITER_BITS-1:0]          max_iter,
   output logic                          rsp_valid,
   input  logic                          rsp_take,
   output logic signed [VALUE_WIDTH-1:0] rsp_root,
   output logic [VALUE_WIDTH-1:0]        rsp_err,
   output logic [ITER_BITS-1:0]          rsp_iter,
   output status_type                    rsp_status
);

   localparam int W       = VALUE_WIDTH;
   localparam int DIV_LEN = W + 7 + FRAC_BITS;
   localparam logic [63:0] HUNDRED_Q = 64'd100 << FRAC_BITS;
   localparam logic [W-1:0] ERR_INIT = HUNDRED_Q[W-1:0];
   localparam logic [W-1:0] VMAX     = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] VMIN     = {1'b1, {(W-1){1'b0}}};
   localparam logic [2*W-1:0] LIM_POS = {{(W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [2*W-1:0] LIM_NEG = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

   logic signed [W-1:0] a_ff, a_in, b_ff, b_in, cur_ff, cur_in, prev_ff, prev_in;
   logic signed [W-1:0] x_ff, x_in, acc_ff, acc_in;
   logic [W-1:0]        err_ff, err_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;
   logic                sa_pos_ff, sa_pos_in, sa_neg_ff, sa_neg_in;
   logic [2*W-1:0]      prod_ff, prod_in;
   logic                pneg_ff, pneg_in;
   logic [DIV_LEN-1:0]  dvd_ff, dvd_in;
   logic [W-1:0]        rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic                over_ff, over_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] rsp_root_ff;
   logic [W-1:0]        rsp_err_ff;
   logic [ITER_BITS-1:0] rsp_iter_ff;
   status_type          rsp_status_ff;

   logic [W-1:0]        acc_mag, x_mag, cur_mag, diff_mag;
   logic [2*W-1:0]      shifted, clipped;
   logic signed [W-1:0] mul_res, coef_pick;
   logic signed [W:0]   sum_ext, mid_sum, diff_ext;
   logic [W+6:0]        num100;
   logic [W:0]          rs, rs_sub;
   logic                ge, acc_pos, acc_neg;
   logic [ITER_BITS-1:0] cap;

   assign acc_mag = acc_ff[W-1] ? W'(-acc_ff) : W'(acc_ff);
   assign x_mag   = x_ff[W-1] ? W'(-x_ff) : W'(x_ff);
   assign cur_mag = cur_ff[W-1] ? W'(-cur_ff) : W'(cur_ff);

   // scale back and clamp the product
   assign shifted = prod_ff >> FRAC_BITS;
   assign clipped = pneg_ff ? ((shifted > LIM_NEG) ? LIM_NEG : shifted)
                            : ((shifted > LIM_POS) ? LIM_POS : shifted);
   assign mul_res = pneg_ff ? -$signed(clipped[W-1:0]) : $signed(clipped[W-1:0]);

   always_comb begin
      unique case (cmd.coef_sel)
         COEF_SQUARE: coef_pick = coef_square;
         COEF_LINEAR: coef_pick = coef_linear;
         default:     coef_pick = coef_constant;
      endcase
   end

   assign sum_ext  = {mul_res[W-1], mul_res} + {coef_pick[W-1], coef_pick};
   assign mid_sum  = {a_ff[W-1], a_ff} + {b_ff[W-1], b_ff};
   assign diff_ext = {cur_ff[W-1], cur_ff} - {prev_ff[W-1], prev_ff};
   assign diff_mag = diff_ext[W] ? W'(-diff_ext) : W'(diff_ext);
   // times 100 as shifts
   assign num100 = ({7'd0, diff_mag} << 6) + ({7'd0, diff_mag} << 5)
                 + ({7'd0, diff_mag} << 2);

   assign rs     = {rem_ff, dvd_ff[DIV_LEN-1]};
   assign ge     = rs >= {1'b0, den_ff};
   assign rs_sub = rs - {1'b0, den_ff};

   assign acc_pos = !acc_ff[W-1] && (acc_ff != '0);
   assign acc_neg = acc_ff[W-1];
   assign cap     = (max_iter == '0) ? ITER_BITS'(1) : max_iter;

   always_comb begin
      a_in = a_ff; b_in = b_ff; cur_in = cur_ff; prev_in = prev_ff;
      x_in = x_ff; acc_in = acc_ff; err_in = err_ff; iter_in = iter_ff;
      sa_pos_in = sa_pos_ff; sa_neg_in = sa_neg_ff;
      prod_in = prod_ff; pneg_in = pneg_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      over_in = over_ff;
      if (cmd.load_req) begin
         a_in = in_low; b_in = in_high; cur_in = '0; prev_in = '0;
         err_in = ERR_INIT; iter_in = '0;
         x_in = in_low; acc_in = coef_cubic;
      end
      if (cmd.eval_high) begin
         x_in = b_ff; acc_in = coef_cubic;
      end
      if (cmd.save_sign) begin
         sa_pos_in = acc_pos; sa_neg_in = acc_neg;
      end
      if (cmd.mul_step) begin
         prod_in = {{W{1'b0}}, acc_mag} * {{W{1'b0}}, x_mag};
         pneg_in = acc_ff[W-1] ^ x_ff[W-1];
      end
      if (cmd.add_step) begin
         if (sum_ext[W] != sum_ext[W-1]) acc_in = sum_ext[W] ? VMIN : VMAX;
         else acc_in = sum_ext[W-1:0];
      end
      if (cmd.mid_step) begin
         prev_in = cur_ff;
         cur_in  = mid_sum[W:1];
         x_in    = mid_sum[W:1];
         acc_in  = coef_cubic;
         iter_in = iter_ff + 1'b1;
      end
      if (cmd.bisect) begin
         if ((sa_pos_ff && acc_neg) || (sa_neg_ff && acc_pos)) begin
            b_in = cur_ff;
         end else begin
            a_in = cur_ff; sa_pos_in = acc_pos; sa_neg_in = acc_neg;
         end
      end
      if (cmd.err_sat) err_in = '1;
      if (cmd.div_start) begin
         dvd_in = {num100, {FRAC_BITS{1'b0}}};
         rem_in = '0; quo_in = '0; over_in = 1'b0; den_in = cur_mag;
      end
      if (cmd.div_step) begin
         rem_in  = ge ? rs_sub[W-1:0] : rs[W-1:0];
         quo_in  = {quo_ff[W-2:0], ge};
         over_in = over_ff | quo_ff[W-1];
         dvd_in  = dvd_ff << 1;
      end
      if (cmd.div_finish) err_in = over_ff ? '1 : quo_ff;
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; cur_ff <= cur_in; prev_ff <= prev_in;
      x_ff <= x_in; acc_ff <= acc_in; err_ff <= err_in; iter_ff <= iter_in;
      sa_pos_ff <= sa_pos_in; sa_neg_ff <= sa_neg_in;
      prod_ff <= prod_in; pneg_ff <= pneg_in;
      dvd_ff <= dvd_in; rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
      over_ff <= over_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_root_ff   <= cur_ff;
         rsp_err_ff    <= err_ff;
         rsp_iter_ff   <= iter_ff;
         rsp_status_ff <= cmd.out_status;
      end
   end

   assign stat.bracket_none = (sa_pos_ff && acc_pos) || (sa_neg_ff && acc_neg);
   assign stat.root_hit     = !(acc_pos || acc_neg) || !(sa_pos_ff || sa_neg_ff);
   assign stat.iter_one     = iter_ff == ITER_BITS'(1);
   assign stat.cur_zero     = cur_ff == '0;
   assign stat.conv_ok      = err_ff <= tolerance;
   assign stat.cap_hit      = iter_ff >= cap;
   assign stat.rsp_free     = !rsp_valid_ff || rsp_take;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_root   = rsp_root_ff;
   assign rsp_err    = rsp_err_ff;
   assign rsp_iter   = rsp_iter_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### src/cubic_bisection_root_finder.sv
`timescale 1ns / 1ps
// cubic root finder by bisection, signed fixed point with FRAC_BITS fraction bits
// req channel: one transaction carries an interval (low, high); one rsp
//   transaction comes back per request with root, error percent, steps and status
// csr channel: writes coefficients, tolerance and iteration cap by index,
//   ready whenever reset is low; write only while no request is in flight
// each polynomial evaluation runs horner's rule on one shared multiplier:
//   three multiply and add rounds plus a sign branch
// bracket check: after the request transaction both interval ends are evaluated
// each bisection step: a midpoint update and an evaluation, then, from the
//   second step on, the bit-serial percent divider, skipped when the step lands
//   on an exact root or the midpoint is zero
// once the result is loaded the controller returns to idle, where the next
//   request is taken
// one request is worked at a time
// the result sits in an output register, so the next request is taken while
//   the receiver stalls; the block holds only once a second result is ready
// reset clears the controller and output valid and restores the register
//   defaults: cubic 1.0, tolerance 1.0 percent, cap 64
module cubic_bisection_root_finder
   import cbrf_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int ITER_BITS   = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // interval_low, interval_high
   input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // root_estimate, approx_error_percent, iterations_done, zero fill
   output logic [((2*VALUE_WIDTH+ITER_BITS+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [VALUE_WIDTH-1:0]     csr_data
);

   localparam int RSP_BITS  = 2 * VALUE_WIDTH + ITER_BITS;
   localparam int RSP_WIDTH = ((RSP_BITS + 7) / 8) * 8;
   localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
   localparam logic [15:0] ITER_RESET = 16'd64;

   logic signed [VALUE_WIDTH-1:0] coef_cubic_ff, coef_square_ff;
   logic signed [VALUE_WIDTH-1:0] coef_linear_ff, coef_constant_ff;
   logic [VALUE_WIDTH-1:0]        tolerance_ff;
   logic [ITER_BITS-1:0]          max_iter_ff;

   cmd_type  cmd;
   stat_type stat;

   logic signed [VALUE_WIDTH-1:0] rsp_root;
   logic [VALUE_WIDTH-1:0]        rsp_err;
   logic [ITER_BITS-1:0]          rsp_iter;
   status_type                    rsp_status;

   assign csr_ready = !reset;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_cubic_ff    <= ONE_Q[VALUE_WIDTH-1:0];
         coef_square_ff   <= '0;
         coef_linear_ff   <= '0;
         coef_constant_ff <= '0;
         tolerance_ff     <= ONE_Q[VALUE_WIDTH-1:0];
         max_iter_ff      <= ITER_RESET[ITER_BITS-1:0];
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COEF_CUBIC:    coef_cubic_ff    <= csr_data;
            CSR_COEF_SQUARE:   coef_square_ff   <= csr_data;
            CSR_COEF_LINEAR:   coef_linear_ff   <= csr_data;
            CSR_COEF_CONSTANT: coef_constant_ff <= csr_data;
            CSR_TOLERANCE:     tolerance_ff     <= csr_data;
            CSR_MAX_ITER:      max_iter_ff      <= csr_data[ITER_BITS-1:0];
            default: ;
         endcase
      end
   end

   cbrf_ctrl #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cbrf_datapath #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .ITER_BITS  (ITER_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_low       (req_tdata[VALUE_WIDTH-1:0]),
      .in_high      (req_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
      .coef_cubic   (coef_cubic_ff),
      .coef_square  (coef_square_ff),
      .coef_linear  (coef_linear_ff),
      .coef_constant(coef_constant_ff),
      .tolerance    (tolerance_ff),
      .max_iter     (max_iter_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_take     (rsp_tready),
      .rsp_root     (rsp_root),
      .rsp_err      (rsp_err),
      .rsp_iter     (rsp_iter),
      .rsp_status   (rsp_status)
   );

   // pack result fields, lowest field first, zero fill to whole bytes
   assign rsp_tdata = RSP_WIDTH'({rsp_iter, rsp_err, rsp_root});
   assign rsp_tuser = rsp_status;

endmodule
